// ===== rtl/bwsc_pkg.sv =====
// Shared types, constants and register codes for the wheel speed controller.
package bwsc_pkg;

  localparam int NUM_SENSORS_DEF = 8;

  localparam int RANGE_W    = 16;
  localparam int SPEED_W    = 15;
  localparam int ANG_W      = 18;
  localparam int GAIN_W     = 8;
  localparam int CLOSE_W    = 13;
  localparam int FRAC_W     = 12;
  localparam int ACC_W      = 24;
  localparam int DIV_W      = 29;
  localparam int DIV_CNT_W  = 5;
  localparam int CL_STEPS   = 13;
  localparam int ANG_STEPS  = 29;
  localparam int TURN_SCALE = 10000;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [CLOSE_W-1:0] CLOSE_FULL = 13'd4096;
  localparam logic [ANG_W-1:0]   ANG_POS_MAX = 18'h1FFFF;
  localparam logic [ANG_W-1:0]   ANG_NEG_MIN = 18'h20000;

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 15'd1229;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 15'd0;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 15'd2048;
  localparam logic [RANGE_W-1:0] NEAR_RST       = 16'd200;
  localparam logic [RANGE_W-1:0] FAR_RST        = 16'd2500;
  localparam logic [RANGE_W-1:0] WHEEL_BASE_RST = 16'd880;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_BASE_SPEED  = 3'd0,
    REG_MIN_SPEED   = 3'd1,
    REG_MAX_SPEED   = 3'd2,
    REG_NEAR        = 3'd3,
    REG_FAR         = 3'd4,
    REG_WHEEL_BASE  = 3'd5,
    REG_LEFT_GAINS  = 3'd6,
    REG_RIGHT_GAINS = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CL_SETUP,
    S_CL_DIV,
    S_MAC,
    S_WHEEL,
    S_MUL,
    S_ANG_SETUP,
    S_ANG_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [RANGE_W-1:0] near_distance;
    logic [RANGE_W-1:0] far_distance;
    logic [RANGE_W-1:0] wheel_base;
    logic [63:0]        left_gains;
    logic [63:0]        right_gains;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [RANGE_W-1:0]   rem_init;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_CNT_W-1:0] steps;
    logic [RANGE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quot;
    logic [RANGE_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/braitenberg_wheel_speed_controller_top.sv =====
// Sequencer and datapath of the wheel speed controller.
// A sample word is taken while idle. A tick word walks every sensor: one whose range is zero or
// at/after far, or any sensor when far is not above near, gets its closeness directly, any other
// through the shared divider; the wheel clamp, product and turn-rate division follow. The shared
// divider yields one quotient bit per cycle. The block takes no word while a tick is in work.
// Synchronous active-low reset clears all ranges to no reading and loads register defaults.
module braitenberg_wheel_speed_controller_top #(
  parameter int NUM_SENSORS = bwsc_pkg::NUM_SENSORS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bwsc_pkg::IN_DATA_W-1:0]       in_tdata,  // sensor_index, range_value
  input  logic [bwsc_pkg::IN_USER_W-1:0]       in_tuser,  // cmd
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bwsc_pkg::OUT_DATA_W-1:0]      out_tdata, // linear_speed, angular_speed
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [bwsc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [bwsc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [bwsc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int SEN_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  bwsc_pkg::cfg_t     cfg;
  bwsc_pkg::div_req_t div_req;
  bwsc_pkg::div_rsp_t div_rsp;
  bwsc_pkg::state_t   state_r, state_nxt;

  logic [bwsc_pkg::RANGE_W-1:0]  ranges_r [NUM_SENSORS];
  logic [SEN_W-1:0]              cnt_r;
  logic [bwsc_pkg::CLOSE_W-1:0]  close_r;
  logic signed [bwsc_pkg::ACC_W-1:0]   acc_l_r, acc_r_r;
  logic signed [bwsc_pkg::SPEED_W-1:0] vl_r, vr_r;
  logic [bwsc_pkg::SPEED_W-1:0]  lin_r;
  logic                          diff_neg_r, diff_zero_r;
  logic [bwsc_pkg::DIV_W-1:0]    prod_r;
  logic [bwsc_pkg::ANG_W-1:0]    ang_r;
  logic                          out_tvalid_r;
  logic [bwsc_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic                          in_acc;
  logic                          is_tick;
  logic [2:0]                    in_idx;
  logic [bwsc_pkg::RANGE_W-1:0]  in_range;
  logic                          idx_ok;
  logic [bwsc_pkg::RANGE_W-1:0]  cur_range;
  logic [bwsc_pkg::RANGE_W-1:0]  dc;
  logic [bwsc_pkg::RANGE_W-1:0]  cl_num;
  logic [bwsc_pkg::RANGE_W-1:0]  cl_den;
  logic                          no_read;
  logic                          full_close;
  logic                          last_sensor;
  logic                          out_free;
  logic signed [bwsc_pkg::GAIN_W-1:0] gl, gr;
  logic signed [21:0]            mac_l, mac_r;
  logic signed [15:0]            raw_l, raw_r;
  logic signed [15:0]            wsum, wdiff;
  logic [bwsc_pkg::SPEED_W-1:0]  mag;
  logic [bwsc_pkg::DIV_W-1:0]    mag_ext;
  logic [bwsc_pkg::DIV_W:0]      neg_mag;
  logic [bwsc_pkg::ANG_W-1:0]    ang_div;

  function automatic logic signed [14:0] clamp_speed(input logic signed [15:0] v,
                                                     input logic signed [14:0] lo,
                                                     input logic signed [14:0] hi);
    logic signed [15:0] t;
    t = v;
    if (t > hi) t = 16'(hi);
    if (t < lo) t = 16'(lo);
    return t[14:0];
  endfunction

  bwsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg)
  );

  bwsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_acc   = in_tvalid && in_tready;
  assign is_tick  = bwsc_pkg::cmd_t'(in_tuser[0]) == bwsc_pkg::CMD_TICK;
  assign in_idx   = in_tdata[2:0];
  assign in_range = in_tdata[18:3];
  assign idx_ok   = 32'(in_idx) < NUM_SENSORS;

  // closeness setup for the sensor under the counter
  assign cur_range   = ranges_r[cnt_r];
  assign no_read     = (cur_range == '0) || (cur_range >= cfg.far_distance);
  assign full_close  = cfg.far_distance <= cfg.near_distance;
  assign dc          = (cur_range < cfg.near_distance) ? cfg.near_distance : cur_range;
  assign cl_num      = cfg.far_distance - dc;
  assign cl_den      = cfg.far_distance - cfg.near_distance;
  assign last_sensor = cnt_r == SEN_W'(NUM_SENSORS - 1);

  assign gl    = $signed(cfg.left_gains[{cnt_r, 3'b000} +: bwsc_pkg::GAIN_W]);
  assign gr    = $signed(cfg.right_gains[{cnt_r, 3'b000} +: bwsc_pkg::GAIN_W]);
  assign mac_l = gl * $signed({1'b0, close_r});
  assign mac_r = gr * $signed({1'b0, close_r});

  // floor of acc / 4096 is the top bits of the accumulator
  assign raw_l = {cfg.base_speed[14], cfg.base_speed}
               + {{4{acc_l_r[bwsc_pkg::ACC_W-1]}}, acc_l_r[bwsc_pkg::ACC_W-1:bwsc_pkg::FRAC_W]};
  assign raw_r = {cfg.base_speed[14], cfg.base_speed}
               + {{4{acc_r_r[bwsc_pkg::ACC_W-1]}}, acc_r_r[bwsc_pkg::ACC_W-1:bwsc_pkg::FRAC_W]};

  assign wsum    = {vl_r[14], vl_r} + {vr_r[14], vr_r};
  assign wdiff   = {vr_r[14], vr_r} - {vl_r[14], vl_r};
  assign mag     = wdiff[15] ? 15'(-wdiff) : wdiff[14:0];
  assign mag_ext = {14'b0, mag};

  // negative quotient rounds toward minus infinity
  assign neg_mag = {1'b0, div_rsp.quot} + {29'b0, (div_rsp.rem != '0)};
  always_comb begin
    if (diff_neg_r) begin
      if (neg_mag > 30'(131072)) ang_div = bwsc_pkg::ANG_NEG_MIN;
      else                       ang_div = ~neg_mag[bwsc_pkg::ANG_W-1:0] + 1'b1;
    end else begin
      if (div_rsp.quot > 29'(131071)) ang_div = bwsc_pkg::ANG_POS_MAX;
      else                            ang_div = div_rsp.quot[bwsc_pkg::ANG_W-1:0];
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwsc_pkg::S_IDLE:      if (in_acc && is_tick) state_nxt = bwsc_pkg::S_CL_SETUP;
      bwsc_pkg::S_CL_SETUP:  state_nxt = (no_read || full_close) ? bwsc_pkg::S_MAC
                                                                 : bwsc_pkg::S_CL_DIV;
      bwsc_pkg::S_CL_DIV:    if (div_rsp.done) state_nxt = bwsc_pkg::S_MAC;
      bwsc_pkg::S_MAC:       state_nxt = last_sensor ? bwsc_pkg::S_WHEEL : bwsc_pkg::S_CL_SETUP;
      bwsc_pkg::S_WHEEL:     state_nxt = bwsc_pkg::S_MUL;
      bwsc_pkg::S_MUL:       state_nxt = bwsc_pkg::S_ANG_SETUP;
      bwsc_pkg::S_ANG_SETUP: state_nxt = (cfg.wheel_base == '0) ? bwsc_pkg::S_DONE
                                                                : bwsc_pkg::S_ANG_DIV;
      bwsc_pkg::S_ANG_DIV:   if (div_rsp.done) state_nxt = bwsc_pkg::S_DONE;
      bwsc_pkg::S_DONE:      if (out_free) state_nxt = bwsc_pkg::S_IDLE;
      default:               state_nxt = bwsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_req   = '0;
    unique case (state_r)
      bwsc_pkg::S_IDLE: in_tready = 1'b1;
      bwsc_pkg::S_CL_SETUP: begin
        div_req.start    = !no_read && !full_close;
        div_req.rem_init = {1'b0, cl_num[bwsc_pkg::RANGE_W-1:1]};
        div_req.dividend = {cl_num[0], 28'b0};
        div_req.steps    = bwsc_pkg::DIV_CNT_W'(bwsc_pkg::CL_STEPS);
        div_req.divisor  = cl_den;
      end
      bwsc_pkg::S_ANG_SETUP: begin
        div_req.start    = cfg.wheel_base != '0;
        div_req.rem_init = '0;
        div_req.dividend = prod_r;
        div_req.steps    = bwsc_pkg::DIV_CNT_W'(bwsc_pkg::ANG_STEPS);
        div_req.divisor  = cfg.wheel_base;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bwsc_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) ranges_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && !is_tick && idx_ok) ranges_r[in_idx[SEN_W-1:0]] <= in_range;
      if (state_r == bwsc_pkg::S_DONE && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready)                         out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bwsc_pkg::S_IDLE: begin
        cnt_r   <= '0;
        acc_l_r <= '0;
        acc_r_r <= '0;
      end
      bwsc_pkg::S_CL_SETUP: begin
        close_r <= (no_read) ? '0 : bwsc_pkg::CLOSE_FULL;
      end
      bwsc_pkg::S_CL_DIV: begin
        if (div_rsp.done) close_r <= div_rsp.quot[bwsc_pkg::CLOSE_W-1:0];
      end
      bwsc_pkg::S_MAC: begin
        acc_l_r <= acc_l_r + {{2{mac_l[21]}}, mac_l};
        acc_r_r <= acc_r_r + {{2{mac_r[21]}}, mac_r};
        cnt_r   <= cnt_r + 1'b1;
      end
      bwsc_pkg::S_WHEEL: begin
        vl_r <= clamp_speed(raw_l, $signed(cfg.min_speed), $signed(cfg.max_speed));
        vr_r <= clamp_speed(raw_r, $signed(cfg.min_speed), $signed(cfg.max_speed));
      end
      bwsc_pkg::S_MUL: begin
        lin_r       <= wsum[15:1];
        diff_neg_r  <= wdiff[15];
        diff_zero_r <= wdiff == '0;
        prod_r      <= mag_ext * bwsc_pkg::DIV_W'(bwsc_pkg::TURN_SCALE);
      end
      bwsc_pkg::S_ANG_SETUP: begin
        if (diff_zero_r)     ang_r <= '0;
        else if (diff_neg_r) ang_r <= bwsc_pkg::ANG_NEG_MIN;
        else                 ang_r <= bwsc_pkg::ANG_POS_MAX;
      end
      bwsc_pkg::S_ANG_DIV: begin
        if (div_rsp.done) ang_r <= ang_div;
      end
      bwsc_pkg::S_DONE: begin
        if (out_free) out_tdata_r <= {7'b0, ang_r, lin_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == bwsc_pkg::S_CL_DIV || state_r == bwsc_pkg::S_ANG_DIV))
    else $error("divider finished outside a wait state");

  a_close_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwsc_pkg::S_MAC) |-> (close_r <= bwsc_pkg::CLOSE_FULL))
    else $error("closeness above full scale");

  a_sample_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_tick) |=> (state_r == bwsc_pkg::S_IDLE))
    else $error("sample word started a tick");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwsc_pkg::S_DONE && out_tvalid_r && !out_tready)
      |=> (state_r == bwsc_pkg::S_DONE && out_tvalid_r))
    else $error("result dropped while output slot busy");
`endif

endmodule

// ===== rtl/bwsc_regs.sv =====
// Configuration register file behind the APB-style port.
module bwsc_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bwsc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bwsc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bwsc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output bwsc_pkg::cfg_t                      cfg_o
);

  bwsc_pkg::cfg_t     cfg_r;
  bwsc_pkg::reg_idx_t sel;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = bwsc_pkg::reg_idx_t'(paddr[bwsc_pkg::CFG_ADDR_W-1:3]);
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed    <= bwsc_pkg::BASE_SPEED_RST;
      cfg_r.min_speed     <= bwsc_pkg::MIN_SPEED_RST;
      cfg_r.max_speed     <= bwsc_pkg::MAX_SPEED_RST;
      cfg_r.near_distance <= bwsc_pkg::NEAR_RST;
      cfg_r.far_distance  <= bwsc_pkg::FAR_RST;
      cfg_r.wheel_base    <= bwsc_pkg::WHEEL_BASE_RST;
      cfg_r.left_gains    <= '0;
      cfg_r.right_gains   <= '0;
    end else if (wr_en) begin
      unique case (sel)
        bwsc_pkg::REG_BASE_SPEED:  cfg_r.base_speed    <= pwdata[bwsc_pkg::SPEED_W-1:0];
        bwsc_pkg::REG_MIN_SPEED:   cfg_r.min_speed     <= pwdata[bwsc_pkg::SPEED_W-1:0];
        bwsc_pkg::REG_MAX_SPEED:   cfg_r.max_speed     <= pwdata[bwsc_pkg::SPEED_W-1:0];
        bwsc_pkg::REG_NEAR:        cfg_r.near_distance <= pwdata[bwsc_pkg::RANGE_W-1:0];
        bwsc_pkg::REG_FAR:         cfg_r.far_distance  <= pwdata[bwsc_pkg::RANGE_W-1:0];
        bwsc_pkg::REG_WHEEL_BASE:  cfg_r.wheel_base    <= pwdata[bwsc_pkg::RANGE_W-1:0];
        bwsc_pkg::REG_LEFT_GAINS:  cfg_r.left_gains    <= pwdata;
        bwsc_pkg::REG_RIGHT_GAINS: cfg_r.right_gains   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bwsc_pkg::REG_BASE_SPEED:  prdata = {49'b0, cfg_r.base_speed};
      bwsc_pkg::REG_MIN_SPEED:   prdata = {49'b0, cfg_r.min_speed};
      bwsc_pkg::REG_MAX_SPEED:   prdata = {49'b0, cfg_r.max_speed};
      bwsc_pkg::REG_NEAR:        prdata = {48'b0, cfg_r.near_distance};
      bwsc_pkg::REG_FAR:         prdata = {48'b0, cfg_r.far_distance};
      bwsc_pkg::REG_WHEEL_BASE:  prdata = {48'b0, cfg_r.wheel_base};
      bwsc_pkg::REG_LEFT_GAINS:  prdata = cfg_r.left_gains;
      bwsc_pkg::REG_RIGHT_GAINS: prdata = cfg_r.right_gains;
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bwsc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module bwsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bwsc_pkg::div_req_t req_i,
  output bwsc_pkg::div_rsp_t rsp_o
);

  logic [bwsc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [bwsc_pkg::RANGE_W-1:0]   rem_r;
  logic [bwsc_pkg::RANGE_W-1:0]   dsr_r;
  logic [bwsc_pkg::DIV_W-1:0]     dvd_r;
  logic [bwsc_pkg::DIV_W-1:0]     quot_r;
  logic [bwsc_pkg::RANGE_W:0]     trial;
  logic [bwsc_pkg::RANGE_W:0]     trial_sub;
  logic                           ge;

  // bring down the next dividend bit and try the divisor
  assign trial     = {rem_r, dvd_r[bwsc_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign ge        = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == bwsc_pkg::DIV_CNT_W'(1));
      if (req_i.start) begin
        cnt_r <= req_i.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r  <= req_i.rem_init;
      dsr_r  <= req_i.divisor;
      dvd_r  <= req_i.dividend;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? trial_sub[bwsc_pkg::RANGE_W-1:0] : trial[bwsc_pkg::RANGE_W-1:0];
      dvd_r  <= {dvd_r[bwsc_pkg::DIV_W-2:0], 1'b0};
      quot_r <= {quot_r[bwsc_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quot = quot_r;
  assign rsp_o.rem  = rem_r;

endmodule
